// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: pre implies post");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: pre implies post next cycle");

`endif

// ===== design/cfrr_pkg.sv =====
package cfrr_pkg;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tx_byte;
        logic [7:0] frame_dest;
        logic [7:0] frame_session;
        logic       last;
    } out_item_t;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_LO = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_BODY   = 3'd3,
        PH_CRC_LO = 3'd4,
        PH_CRC_HI = 3'd5,
        PH_TAIL   = 3'd6
    } phase_t;

    localparam logic       OP_BYTE    = 1'b0;
    localparam logic       OP_TIMEOUT = 1'b1;

    localparam logic [1:0] KIND_CRC_ERR = 2'd0;
    localparam logic [1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [1:0] KIND_REPLY   = 2'd2;

    localparam logic [7:0]  SOH_BYTE        = 8'h01;
    localparam logic [7:0]  EOT_BYTE        = 8'h04;
    localparam logic [7:0]  REPLY_LEN_BYTE  = 8'h03;
    localparam logic [7:0]  ZERO_BYTE       = 8'h00;
    localparam logic [15:0] CRC16_GENERATOR = 16'h1021;
    localparam logic [2:0]  POS_SAT         = 3'd6;
    localparam logic [2:0]  POS_DEST        = 3'd3;
    localparam logic [2:0]  POS_SESSION     = 3'd5;
    localparam logic [3:0]  REPLY_LAST_IDX  = 4'd8;
    localparam logic [3:0]  REPLY_CRC_END   = 4'd5;

    // CRC-16, poly 0x1021, MSB first, one byte unrolled over eight bit steps.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC16_GENERATOR;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== design/crc_checked_frame_receiver_core.sv =====
// SOH-framed serial receiver with CRC-16 check and a 9-byte reply.
// Input channel (s_valid/s_ready/s_item): one transaction per line byte
// (op = byte) or per receive timeout (op = timeout). Output channel
// (m_valid/m_ready/m_item): result transactions. A frame that ends with a
// bad CRC gives one CRC-error result; a good frame gives an "accepted"
// result and then nine reply bytes, the final one flagged with last.
// Every result carries frame bytes 3 and 5 of the frame just ended.
// reg_wr_en/reg_wr_data write the reply destination address (reset 0).
// An input transaction is captured in the input register and its result is
// then registered in the output register that drives m_valid/m_item.
// Throughput: one transaction per cycle unless the output stalls or a
// reply is sequenced; the CRC step is one byte unrolled between the input
// and state registers. A good frame end holds the input side while the
// reply sequencer issues the nine reply bytes behind the accepted result.
// Reset (aresetn low, synchronous): hunt for SOH, clear counters, frame CRCs,
// captured bytes and the address register; both channels go idle.
// Output stall: results hold in the output register; one more input
// transaction may be taken into the input register meanwhile.
`include "assert_macros.svh"

module crc_checked_frame_receiver_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cfrr_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output cfrr_pkg::out_item_t m_item,
    input  logic                reg_wr_en,
    input  logic [7:0]          reg_wr_data
);
    import cfrr_pkg::*;

    // Input register
    logic       in_valid_reg;
    in_item_t   in_item_reg;

    // Frame state
    phase_t      phase_reg, phase_next;
    logic [15:0] body_length_reg, body_length_next;
    logic [15:0] body_count_reg, body_count_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic [15:0] received_crc_reg, received_crc_next;
    logic [2:0]  frame_pos_reg, frame_pos_next;
    logic [7:0]  cap_dest_reg, cap_dest_next;
    logic [7:0]  cap_session_reg, cap_session_next;
    logic [7:0]  dest_addr_reg;

    // Result register and reply sequencer
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_item_reg, m_item_next;
    logic        seq_active_reg, seq_active_next;
    logic [3:0]  seq_idx_reg, seq_idx_next;
    logic [15:0] reply_crc_reg, reply_crc_next;

    logic        out_free;
    logic        pop;
    logic        emit_err;
    logic        emit_ok;
    logic [15:0] crc_step;
    logic [7:0]  reply_byte;
    logic [7:0]  b;

    assign out_free = !m_valid_reg || m_ready;
    // Advance the input register only when the result slot is free and no reply is being sequenced.
    assign pop      = in_valid_reg && !seq_active_reg && out_free;
    assign s_ready  = !in_valid_reg || pop;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;
    assign b        = in_item_reg.rx_byte;
    assign crc_step = crc16_byte(running_crc_reg, b);

    // Frame parser: next state for the popped transaction.
    always_comb begin
        phase_next        = phase_reg;
        body_length_next  = body_length_reg;
        body_count_next   = body_count_reg;
        running_crc_next  = running_crc_reg;
        received_crc_next = received_crc_reg;
        frame_pos_next    = frame_pos_reg;
        cap_dest_next     = cap_dest_reg;
        cap_session_next  = cap_session_reg;
        emit_err          = 1'b0;
        emit_ok           = 1'b0;
        if (pop) begin
            if (in_item_reg.op == OP_TIMEOUT) begin
                // Drop the frame in progress.
                phase_next = PH_HUNT;
            end else if (phase_reg == PH_HUNT || phase_reg > PH_TAIL) begin
                if (b == SOH_BYTE) begin
                    running_crc_next = crc16_byte(16'h0000, b);
                    frame_pos_next   = 3'd1;
                    body_count_next  = 16'h0000;
                    phase_next       = PH_LEN_LO;
                end else begin
                    phase_next = PH_HUNT;
                end
            end else begin
                if (frame_pos_reg == POS_DEST) begin
                    cap_dest_next = b;
                end
                if (frame_pos_reg == POS_SESSION) begin
                    cap_session_next = b;
                end
                if (frame_pos_reg < POS_SAT) begin
                    frame_pos_next = frame_pos_reg + 3'd1;
                end
                case (phase_reg)
                    PH_LEN_LO: begin
                        body_length_next = {8'h00, b};
                        running_crc_next = crc_step;
                        phase_next       = PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        body_length_next = {b, body_length_reg[7:0]};
                        running_crc_next = crc_step;
                        body_count_next  = 16'h0000;
                        phase_next = ({b, body_length_reg[7:0]} == 16'h0000) ? PH_CRC_LO : PH_BODY;
                    end
                    PH_BODY: begin
                        running_crc_next = crc_step;
                        body_count_next  = body_count_reg + 16'd1;
                        if (body_count_reg + 16'd1 == body_length_reg) begin
                            phase_next = PH_CRC_LO;
                        end
                    end
                    PH_CRC_LO: begin
                        received_crc_next = {8'h00, b};
                        phase_next        = PH_CRC_HI;
                    end
                    PH_CRC_HI: begin
                        received_crc_next = {b, received_crc_reg[7:0]};
                        phase_next        = PH_TAIL;
                    end
                    default: begin
                        // Tail byte: the frame ends, compare the CRCs.
                        phase_next = PH_HUNT;
                        if (received_crc_reg == running_crc_reg) begin
                            emit_ok = 1'b1;
                        end else begin
                            emit_err = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // Reply byte at the sequencer position.
    always_comb begin
        case (seq_idx_reg)
            4'd0:    reply_byte = SOH_BYTE;
            4'd1:    reply_byte = REPLY_LEN_BYTE;
            4'd2:    reply_byte = ZERO_BYTE;
            4'd3:    reply_byte = dest_addr_reg;
            4'd4:    reply_byte = cap_dest_reg;
            4'd5:    reply_byte = cap_session_reg;
            4'd6:    reply_byte = reply_crc_reg[7:0];
            4'd7:    reply_byte = reply_crc_reg[15:8];
            default: reply_byte = EOT_BYTE;
        endcase
    end

    // Result register loading and reply sequencing.
    always_comb begin
        m_valid_next    = m_valid_reg && !m_ready;
        m_item_next     = m_item_reg;
        seq_active_next = seq_active_reg;
        seq_idx_next    = seq_idx_reg;
        reply_crc_next  = reply_crc_reg;
        if (emit_err || emit_ok) begin
            m_valid_next              = 1'b1;
            m_item_next.kind          = emit_ok ? KIND_ACCEPT : KIND_CRC_ERR;
            m_item_next.tx_byte       = ZERO_BYTE;
            m_item_next.frame_dest    = cap_dest_next;
            m_item_next.frame_session = cap_session_next;
            m_item_next.last          = emit_err;
            seq_active_next           = emit_ok;
            seq_idx_next              = 4'd0;
            reply_crc_next            = 16'h0000;
        end else if (seq_active_reg && out_free) begin
            m_valid_next              = 1'b1;
            m_item_next.kind          = KIND_REPLY;
            m_item_next.tx_byte       = reply_byte;
            m_item_next.frame_dest    = cap_dest_reg;
            m_item_next.frame_session = cap_session_reg;
            m_item_next.last          = (seq_idx_reg == REPLY_LAST_IDX);
            seq_idx_next              = seq_idx_reg + 4'd1;
            if (seq_idx_reg == REPLY_LAST_IDX) begin
                seq_active_next = 1'b0;
            end
            // Fold the first six reply bytes into the reply CRC.
            if (seq_idx_reg <= REPLY_CRC_END) begin
                reply_crc_next = crc16_byte(reply_crc_reg, reply_byte);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            phase_reg        <= PH_HUNT;
            body_length_reg  <= 16'h0000;
            body_count_reg   <= 16'h0000;
            running_crc_reg  <= 16'h0000;
            received_crc_reg <= 16'h0000;
            frame_pos_reg    <= 3'd0;
            cap_dest_reg     <= 8'h00;
            cap_session_reg  <= 8'h00;
            dest_addr_reg    <= 8'h00;
            m_valid_reg      <= 1'b0;
            seq_active_reg   <= 1'b0;
            seq_idx_reg      <= 4'd0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (pop) begin
                in_valid_reg <= 1'b0;
            end
            phase_reg        <= phase_next;
            body_length_reg  <= body_length_next;
            body_count_reg   <= body_count_next;
            running_crc_reg  <= running_crc_next;
            received_crc_reg <= received_crc_next;
            frame_pos_reg    <= frame_pos_next;
            cap_dest_reg     <= cap_dest_next;
            cap_session_reg  <= cap_session_next;
            if (reg_wr_en) begin
                dest_addr_reg <= reg_wr_data;
            end
            m_valid_reg      <= m_valid_next;
            seq_active_reg   <= seq_active_next;
            seq_idx_reg      <= seq_idx_next;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        m_item_reg    <= m_item_next;
        reply_crc_reg <= reply_crc_next;
    end

    // While the reply is sequenced a result is always on the output.
    `ASSERT_SAME(a_seq_has_result, aclk, aresetn, seq_active_reg, m_valid_reg)
    // A result without last is always followed by more reply bytes.
    `ASSERT_SAME(a_not_last_seq, aclk, aresetn, m_valid_reg && !m_item_reg.last, seq_active_reg)
    // The input side is held while the reply is sequenced.
    `ASSERT_SAME(a_hold_input, aclk, aresetn, seq_active_reg, !pop)
    // A good frame end shows the accepted result next.
    `ASSERT_NEXT(a_ok_result, aclk, aresetn, emit_ok, m_valid_reg && m_item_reg.kind == KIND_ACCEPT)
    // Only reply bytes carry a nonzero transmit byte.
    `ASSERT_SAME(a_tx_zero, aclk, aresetn, m_valid_reg && m_item_reg.kind != KIND_REPLY, m_item_reg.tx_byte == 8'h00)

endmodule

// ===== bench/tb_crc_checked_frame_receiver_core.sv =====
`timescale 1ns / 1ps

module tb_crc_checked_frame_receiver_core;
    import cfrr_pkg::*;

    // How a stimulus row is judged: by the frame predictor, as owing no result,
    // or by a result typed straight into the table.
    typedef enum logic [1:0] {
        BY_MODEL  = 2'd0,
        NO_RESULT = 2'd1,
        CRC_FAIL  = 2'd2
    } row_check_t;

    typedef struct packed {
        row_check_t check;
        logic       op;
        logic [7:0] rx_byte;
        logic [7:0] dest;
        logic [7:0] sess;
    } stim_row_t;

    // Clock, reset and DUT ports
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_item = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_item;
    logic        reg_wr_en = 1'b0;
    logic [7:0]  reg_wr_data = 8'h00;

    always #6 aclk = ~aclk;

    crc_checked_frame_receiver_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .reg_wr_en   (reg_wr_en),
        .reg_wr_data (reg_wr_data)
    );

    // Receiver state as the predictor sees it; these start at reset values.
    phase_t      rx_phase = PH_HUNT;
    logic [15:0] body_len = 16'h0000;
    logic [15:0] body_seen = 16'h0000;
    logic [15:0] line_crc = 16'h0000;
    logic [15:0] sent_crc = 16'h0000;
    logic [2:0]  frame_pos = 3'd0;
    logic [7:0]  cap_dest = 8'h00;
    logic [7:0]  cap_sess = 8'h00;
    logic [7:0]  reply_addr = 8'h00;

    out_item_t   fresh_results[$];      // results caused by the latest transaction
    out_item_t   frame_results_due[$];  // results the DUT still owes, oldest first
    out_item_t   due;
    int unsigned mismatches = 0;
    bit          no_gaps = 1'b0;        // when set, neither side idles

    // Directed rows: noise while hunting, a zero-length frame with a bad CRC
    // (bytes 3 and 5 are then the CRC low byte and the tail byte), the same
    // frame with its correct CRC 0x3730, and two frames cut off by timeouts.
    stim_row_t directed_rows[21] = '{
        '{NO_RESULT, OP_TIMEOUT, 8'h00, 8'h00, 8'h00},
        '{NO_RESULT, OP_BYTE,    8'hFF, 8'h00, 8'h00},
        '{NO_RESULT, OP_BYTE,    8'h00, 8'h00, 8'h00},
        '{NO_RESULT, OP_BYTE,    8'h01, 8'h00, 8'h00},
        '{NO_RESULT, OP_BYTE,    8'h00, 8'h00, 8'h00},
        '{NO_RESULT, OP_BYTE,    8'h00, 8'h00, 8'h00},
        '{NO_RESULT, OP_BYTE,    8'hAA, 8'h00, 8'h00},
        '{NO_RESULT, OP_BYTE,    8'h55, 8'h00, 8'h00},
        '{CRC_FAIL,  OP_BYTE,    8'hFF, 8'hAA, 8'hFF},
        '{BY_MODEL,  OP_BYTE,    8'h01, 8'h00, 8'h00},
        '{BY_MODEL,  OP_BYTE,    8'h00, 8'h00, 8'h00},
        '{BY_MODEL,  OP_BYTE,    8'h00, 8'h00, 8'h00},
        '{BY_MODEL,  OP_BYTE,    8'h30, 8'h00, 8'h00},
        '{BY_MODEL,  OP_BYTE,    8'h37, 8'h00, 8'h00},
        '{BY_MODEL,  OP_BYTE,    8'h00, 8'h00, 8'h00},
        '{NO_RESULT, OP_BYTE,    8'h01, 8'h00, 8'h00},
        '{NO_RESULT, OP_BYTE,    8'h05, 8'h00, 8'h00},
        '{NO_RESULT, OP_BYTE,    8'h00, 8'h00, 8'h00},
        '{NO_RESULT, OP_TIMEOUT, 8'hFF, 8'h00, 8'h00},
        '{NO_RESULT, OP_BYTE,    8'h01, 8'h00, 8'h00},
        '{NO_RESULT, OP_TIMEOUT, 8'h00, 8'h00, 8'h00}
    };

    // CRC-16/XMODEM, one data bit at a time, MSB first.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC16_GENERATOR;
            end
        end
        return c;
    endfunction

    function automatic out_item_t frame_result(input logic [1:0] kind, input logic [7:0] tx,
                                               input logic last);
        return '{kind: kind, tx_byte: tx, frame_dest: cap_dest,
                 frame_session: cap_sess, last: last};
    endfunction

    // Advance the receiver by one transaction; leave its results in fresh_results.
    task automatic advance_receiver(input in_item_t it);
        logic [7:0]  reply[9];
        logic [15:0] c;
        fresh_results.delete();
        if (it.op == OP_TIMEOUT) begin
            rx_phase = PH_HUNT;
            return;
        end
        if (rx_phase == PH_HUNT) begin
            if (it.rx_byte == SOH_BYTE) begin
                line_crc = crc_fold(16'h0000, it.rx_byte);
                frame_pos = 3'd1;
                body_seen = 16'h0000;
                rx_phase = PH_LEN_LO;
            end
            return;
        end
        if (frame_pos == POS_DEST) begin
            cap_dest = it.rx_byte;
        end
        if (frame_pos == POS_SESSION) begin
            cap_sess = it.rx_byte;
        end
        if (frame_pos < POS_SAT) begin
            frame_pos = frame_pos + 3'd1;
        end
        case (rx_phase)
            PH_LEN_LO: begin
                body_len = {8'h00, it.rx_byte};
                line_crc = crc_fold(line_crc, it.rx_byte);
                rx_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                body_len[15:8] = it.rx_byte;
                line_crc = crc_fold(line_crc, it.rx_byte);
                body_seen = 16'h0000;
                rx_phase = (body_len == 16'h0000) ? PH_CRC_LO : PH_BODY;
            end
            PH_BODY: begin
                line_crc = crc_fold(line_crc, it.rx_byte);
                body_seen = body_seen + 16'h0001;
                if (body_seen == body_len) begin
                    rx_phase = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                sent_crc = {8'h00, it.rx_byte};
                rx_phase = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                sent_crc[15:8] = it.rx_byte;
                rx_phase = PH_TAIL;
            end
            default: begin
                // Tail byte: close the frame, then judge it.
                rx_phase = PH_HUNT;
                if (sent_crc != line_crc) begin
                    fresh_results.push_back(frame_result(KIND_CRC_ERR, ZERO_BYTE, 1'b1));
                end else begin
                    reply[0] = SOH_BYTE;
                    reply[1] = REPLY_LEN_BYTE;
                    reply[2] = ZERO_BYTE;
                    reply[3] = reply_addr;
                    reply[4] = cap_dest;
                    reply[5] = cap_sess;
                    c = 16'h0000;
                    for (int i = 0; i < 6; i++) begin
                        c = crc_fold(c, reply[i]);
                    end
                    reply[6] = c[7:0];
                    reply[7] = c[15:8];
                    reply[8] = EOT_BYTE;
                    fresh_results.push_back(frame_result(KIND_ACCEPT, ZERO_BYTE, 1'b0));
                    for (int i = 0; i < 9; i++) begin
                        fresh_results.push_back(frame_result(KIND_REPLY, reply[i],
                                                             i == REPLY_LAST_IDX));
                    end
                end
            end
        endcase
    endtask

    // Offer one input transaction after a random gap and hold it until taken.
    // Enter and leave at a falling edge; keep s_valid high when no gap follows.
    task automatic send_item(input in_item_t it, input row_check_t check,
                             input logic [7:0] dest, input logic [7:0] sess);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        advance_receiver(it);
        case (check)
            BY_MODEL: begin
                foreach (fresh_results[i]) frame_results_due.push_back(fresh_results[i]);
            end
            CRC_FAIL: begin
                frame_results_due.push_back('{kind: KIND_CRC_ERR, tx_byte: ZERO_BYTE,
                                              frame_dest: dest, frame_session: sess,
                                              last: 1'b1});
            end
            default: begin
            end
        endcase
        @(negedge aclk);
    endtask

    // Build one frame with random body and send it. Flip one CRC bit when
    // corrupt is set; when cut is non-negative, drop the frame by a timeout
    // in place of byte number cut.
    task automatic send_frame(input logic [15:0] blen, input bit corrupt, input int cut,
                              inout int unsigned sent);
        in_item_t    seq[$];
        logic [15:0] crc;
        logic [7:0]  b;
        seq.push_back('{op: OP_BYTE, rx_byte: SOH_BYTE});
        crc = crc_fold(16'h0000, SOH_BYTE);
        seq.push_back('{op: OP_BYTE, rx_byte: blen[7:0]});
        crc = crc_fold(crc, blen[7:0]);
        seq.push_back('{op: OP_BYTE, rx_byte: blen[15:8]});
        crc = crc_fold(crc, blen[15:8]);
        for (int i = 0; i < blen; i++) begin
            b = 8'($urandom_range(0, 255));
            seq.push_back('{op: OP_BYTE, rx_byte: b});
            crc = crc_fold(crc, b);
        end
        if (corrupt) begin
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        end
        seq.push_back('{op: OP_BYTE, rx_byte: crc[7:0]});
        seq.push_back('{op: OP_BYTE, rx_byte: crc[15:8]});
        seq.push_back('{op: OP_BYTE, rx_byte: 8'($urandom_range(0, 255))});
        if (cut >= 0) begin
            while (seq.size() > cut) void'(seq.pop_back());
            seq.push_back('{op: OP_TIMEOUT, rx_byte: 8'($urandom_range(0, 255))});
        end
        foreach (seq[i]) send_item(seq[i], BY_MODEL, 8'h00, 8'h00);
        sent += seq.size();
    endtask

    // Mostly short bodies, some a little longer.
    function automatic logic [15:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 14) begin
            return 16'($urandom_range(0, 6));
        end
        return 16'($urandom_range(7, 12));
    endfunction

    // Drop valid, wait out every owed result, then let the pipeline drain
    // of transactions that cause nothing (input and output registers, plus margin).
    task automatic settle_pipeline();
        s_valid <= 1'b0;
        while (frame_results_due.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Write the reply address while the block is idle; the predictor follows.
    task automatic set_reply_address(input logic [7:0] addr);
        reg_wr_en   <= 1'b1;
        reg_wr_data <= addr;
        @(negedge aclk);
        reg_wr_en   <= 1'b0;
        reply_addr = addr;
    endtask

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        end
    endtask

    // Result side: hold off ready for a random number of cycles per
    // transaction, then wait for the DUT to present one.
    initial begin
        int unsigned hold;
        @(negedge aclk);
        forever begin
            hold = no_gaps ? 0 : $urandom_range(0, 4);
            if (hold != 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Score every accepted result against the oldest one owed.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (frame_results_due.size() == 0) begin
                mismatches++;
                $error("result with nothing owed: kind %0d tx_byte 0x%0h",
                       m_item.kind, m_item.tx_byte);
            end else begin
                due = frame_results_due.pop_front();
                compare_field("kind", 8'(due.kind), 8'(m_item.kind));
                compare_field("tx_byte", due.tx_byte, m_item.tx_byte);
                compare_field("frame_dest", due.frame_dest, m_item.frame_dest);
                compare_field("frame_session", due.frame_session, m_item.frame_session);
                compare_field("last", 8'(due.last), 8'(m_item.last));
            end
        end
    end

    // Stimulus: reset, directed table, then random phases under several
    // reply addresses, then a frame announcing the largest body length,
    // cut off by a timeout.
    initial begin
        logic [7:0]  addr;
        logic [15:0] len;
        int unsigned sent;
        int unsigned noise;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part runs with the reset value of the reply address.
        foreach (directed_rows[i]) begin
            send_item('{op: directed_rows[i].op, rx_byte: directed_rows[i].rx_byte},
                      directed_rows[i].check, directed_rows[i].dest, directed_rows[i].sess);
        end
        settle_pipeline();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: addr = 8'hFF;
                1: addr = 8'h00;
                default: addr = 8'($urandom_range(0, 255));
            endcase
            set_reply_address(addr);
            sent = 0;
            while (sent < 20) begin
                no_gaps = ($urandom_range(0, 5) == 0);
                len = pick_length();
                case ($urandom_range(0, 9))
                    0: begin
                        // Line noise of bytes and timeouts; end on a timeout
                        // to resync in case an SOH slipped in.
                        noise = $urandom_range(1, 3);
                        repeat (noise) begin
                            send_item('{op: 1'($urandom_range(0, 1)),
                                        rx_byte: 8'($urandom_range(0, 255))},
                                      BY_MODEL, 8'h00, 8'h00);
                        end
                        send_item('{op: OP_TIMEOUT, rx_byte: 8'($urandom_range(0, 255))},
                                  BY_MODEL, 8'h00, 8'h00);
                        sent += noise + 1;
                    end
                    1: send_frame(len, 1'b0, $urandom_range(1, len + 5), sent);
                    2, 3: send_frame(len, 1'b1, -1, sent);
                    default: send_frame(len, 1'b0, -1, sent);
                endcase
            end
            settle_pipeline();
        end

        // Largest body length the field allows, dropped a few bytes in.
        no_gaps = 1'b0;
        set_reply_address(8'($urandom_range(0, 255)));
        send_frame(16'hFFFF, 1'b0, $urandom_range(3, 8), sent);
        settle_pipeline();
        repeat (6) @(posedge aclk);

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/cfrr_pkg.sv
design/crc_checked_frame_receiver_core.sv
bench/tb_crc_checked_frame_receiver_core.sv
